@@ rtl/fsnb_pkg.sv @@
// Shared types and constants for the FAT short name builder.
// Used by the front, queue, back and top level modules; no dependencies.
package fsnb_pkg;

   // Name store and short name geometry
   localparam int STORE_DEPTH = 12;
   localparam int STORE_IDX_W = 4;
   localparam logic [3:0] STORE_LAST_IDX = 4'd11;
   localparam logic [3:0] SHORT_LAST_BYTE = 4'd10;
   localparam logic [3:0] EXT_POS = 4'd8;
   localparam logic [3:0] COUNT_MAX = 4'd15;
   localparam logic [3:0] BASE_MAX_LEN = 4'd11;
   localparam logic [3:0] DOTTED_MAX_LEN = 4'd12;
   localparam logic [3:0] DOT_MAX_IDX = 4'd8;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   // Character codes
   localparam logic [15:0] CH_E5_ESC = 16'h0005;
   localparam logic [15:0] CH_CTRL_END = 16'h0020;
   localparam logic [15:0] CH_DOT = 16'h002E;
   localparam logic [15:0] CH_ASCII_TOP = 16'h007E;
   localparam logic [15:0] CH_SURR_LO = 16'hD800;
   localparam logic [15:0] CH_SURR_HI = 16'hDFFF;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_LOWER_A = 8'h61;
   localparam logic [7:0] BYTE_LOWER_Z = 8'h7A;

   // Name classes
   localparam logic [1:0] CLASS_SHORT = 2'd0;
   localparam logic [1:0] CLASS_LONG = 2'd1;
   localparam logic [1:0] CLASS_INVALID = 2'd2;

   // One classified name handed from front to back
   typedef struct packed {
      logic [1:0] name_class;
      logic dot_seen;
      logic [3:0] dot_index;
      logic [3:0] char_count;
      logic [STORE_DEPTH-1:0][7:0] chars;
   } entry_type;

   // Map 'a'..'z' to upper case, leave everything else
   function automatic logic [7:0] upper_byte(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= BYTE_LOWER_A && c <= BYTE_LOWER_Z) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

endpackage

@@ rtl/fsnb_front.sv @@
// Front end: accepts name characters, stores low bytes, classifies the name.
// Depends on fsnb_pkg; pushes one entry per name into fsnb_queue.
module fsnb_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic [15:0] req_name_char,
   input  logic req_last_char,
   output logic push,
   output fsnb_pkg::entry_type push_entry
);

   logic [fsnb_pkg::STORE_DEPTH-1:0][7:0] store_ff, store_in;
   logic [3:0] count_ff, count_in;
   logic [3:0] dot_idx_ff, dot_idx_in;
   logic dot_seen_ff, dot_seen_in;
   logic long_ff, long_in;
   logic invalid_ff, invalid_in;
   logic accept;
   logic is_invalid, is_long_ch, is_dot, too_long;

   assign accept = req_valid && !req_stall;

   // Classify the incoming character
   assign is_invalid = (req_name_char < fsnb_pkg::CH_CTRL_END &&
                        req_name_char != fsnb_pkg::CH_E5_ESC) ||
                       (req_name_char >= fsnb_pkg::CH_SURR_LO &&
                        req_name_char <= fsnb_pkg::CH_SURR_HI);
   assign is_long_ch = req_name_char > fsnb_pkg::CH_ASCII_TOP;
   assign is_dot = req_name_char == fsnb_pkg::CH_DOT;

   // Compute the name state including this character
   always_comb begin
      store_in = store_ff;
      if (count_ff <= fsnb_pkg::STORE_LAST_IDX) begin
         store_in[count_ff] = req_name_char[7:0];
      end
      count_in = (count_ff == fsnb_pkg::COUNT_MAX) ? count_ff : count_ff + 4'd1;
      dot_seen_in = dot_seen_ff || is_dot;
      dot_idx_in = is_dot ? count_ff : dot_idx_ff;
      invalid_in = invalid_ff || is_invalid;
      too_long = dot_seen_in ?
                 (dot_idx_in > fsnb_pkg::DOT_MAX_IDX || count_in > fsnb_pkg::DOTTED_MAX_LEN) :
                 (count_in > fsnb_pkg::BASE_MAX_LEN);
      long_in = long_ff || is_long_ch || (req_last_char && too_long);
   end

   // Build the entry on the final character
   assign push = accept && req_last_char;
   always_comb begin
      push_entry.name_class = invalid_in ? fsnb_pkg::CLASS_INVALID :
                              (long_in ? fsnb_pkg::CLASS_LONG : fsnb_pkg::CLASS_SHORT);
      push_entry.dot_seen = dot_seen_in;
      push_entry.dot_index = dot_idx_in;
      push_entry.char_count = count_in;
      push_entry.chars = store_in;
   end

   // Advance name state; clear it after the final character
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         dot_idx_ff <= '0;
         dot_seen_ff <= 1'b0;
         long_ff <= 1'b0;
         invalid_ff <= 1'b0;
      end else if (accept) begin
         if (req_last_char) begin
            count_ff <= '0;
            dot_idx_ff <= '0;
            dot_seen_ff <= 1'b0;
            long_ff <= 1'b0;
            invalid_ff <= 1'b0;
         end else begin
            count_ff <= count_in;
            dot_idx_ff <= dot_idx_in;
            dot_seen_ff <= dot_seen_in;
            long_ff <= long_in;
            invalid_ff <= invalid_in;
         end
      end
   end

   // Hold character bytes
   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff <= store_in;
      end
   end

endmodule

@@ rtl/fsnb_queue.sv @@
// Two-entry queue of classified names between front and back.
// Depends on fsnb_pkg for the entry type and depth.
module fsnb_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  fsnb_pkg::entry_type push_entry,
   input  logic pop,
   output fsnb_pkg::entry_type pop_entry,
   output logic empty,
   output logic full
);

   fsnb_pkg::entry_type slots_ff [fsnb_pkg::QUEUE_DEPTH];
   logic [fsnb_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [fsnb_pkg::QCNT_W-1:0] count_ff;

   assign empty = count_ff == '0;
   assign full = count_ff == fsnb_pkg::QCNT_W'(fsnb_pkg::QUEUE_DEPTH);
   assign pop_entry = slots_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Write the entry
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fsnb_pkg::QCNT_W'(fsnb_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

@@ rtl/fsnb_back.sv @@
// Back end: takes one name entry and emits its short name bytes with checksum.
// Depends on fsnb_pkg; pops entries from fsnb_queue.
module fsnb_back (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  fsnb_pkg::entry_type q_entry,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_name_class,
   output logic [3:0] rsp_byte_index,
   output logic [7:0] rsp_short_byte,
   output logic [7:0] rsp_checksum,
   output logic rsp_last_result
);

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;

   state_type state_ff;
   fsnb_pkg::entry_type cur_ff;
   logic [3:0] k_ff;
   logic [7:0] sum_ff;
   logic rsp_valid_ff;
   logic [1:0] class_ff;
   logic [3:0] index_ff;
   logic [7:0] byte_ff;
   logic [7:0] csum_ff;
   logic last_ff;

   logic slot_free;
   logic [4:0] src_idx;
   logic use_space;
   logic [7:0] byte_in;
   logic [7:0] sum_in;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop = (state_ff == ST_IDLE) && !q_empty;

   // Select the source character for byte k
   always_comb begin
      use_space = 1'b0;
      src_idx = {1'b0, k_ff};
      if (cur_ff.dot_seen) begin
         if (k_ff < fsnb_pkg::EXT_POS) begin
            use_space = k_ff >= cur_ff.dot_index;
         end else begin
            src_idx = {1'b0, cur_ff.dot_index} + 5'd1 + {1'b0, k_ff - fsnb_pkg::EXT_POS};
         end
      end
      if (use_space || src_idx >= {1'b0, cur_ff.char_count} ||
          src_idx > {1'b0, fsnb_pkg::STORE_LAST_IDX}) begin
         byte_in = fsnb_pkg::BYTE_SPACE;
      end else begin
         byte_in = fsnb_pkg::upper_byte(cur_ff.chars[src_idx[fsnb_pkg::STORE_IDX_W-1:0]]);
      end
      sum_in = {sum_ff[0], sum_ff[7:1]} + byte_in;
   end

   // Sequence the entry and hold the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (!q_empty) begin
                  cur_ff <= q_entry;
                  k_ff <= '0;
                  sum_ff <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  class_ff <= cur_ff.name_class;
                  if (cur_ff.name_class != fsnb_pkg::CLASS_SHORT) begin
                     index_ff <= '0;
                     byte_ff <= fsnb_pkg::BYTE_SPACE;
                     csum_ff <= '0;
                     last_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     index_ff <= k_ff;
                     byte_ff <= byte_in;
                     csum_ff <= sum_in;
                     sum_ff <= sum_in;
                     last_ff <= k_ff == fsnb_pkg::SHORT_LAST_BYTE;
                     k_ff <= k_ff + 4'd1;
                     if (k_ff == fsnb_pkg::SHORT_LAST_BYTE) begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end
            default: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b0;
               end
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_name_class = class_ff;
   assign rsp_byte_index = index_ff;
   assign rsp_short_byte = byte_ff;
   assign rsp_checksum = csum_ff;
   assign rsp_last_result = last_ff;

   a_other_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && class_ff != fsnb_pkg::CLASS_SHORT |->
         last_ff && index_ff == '0 && byte_ff == fsnb_pkg::BYTE_SPACE)
      else $error("long or invalid name must give one result");
   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && class_ff == fsnb_pkg::CLASS_SHORT |->
         last_ff == (index_ff == fsnb_pkg::SHORT_LAST_BYTE))
      else $error("last flag not on final short name byte");
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> k_ff <= fsnb_pkg::SHORT_LAST_BYTE)
      else $error("byte counter ran past short name");

endmodule

@@ rtl/fat_short_name_builder.sv @@
// Builds a FAT 8.3 short name with LFN checksum from a stream of UCS-2
// characters. Each character transaction is taken while req_stall is low; a
// name ends with the transaction that carries req_last_char. A valid 8.3 name
// then gives eleven result transactions (uppercased bytes, extension at byte
// 8, running checksum), a long or invalid name gives one. The back end loads a
// name from the queue and then emits its results in turn, holding while
// rsp_stall is high; a two-name queue lets the next names load meanwhile, and
// req_stall rises only while that queue is full.
// Depends on fsnb_pkg, fsnb_front, fsnb_queue and fsnb_back.
module fat_short_name_builder (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [15:0] req_name_char,
   input  logic req_last_char,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_name_class,
   output logic [3:0] rsp_byte_index,
   output logic [7:0] rsp_short_byte,
   output logic [7:0] rsp_checksum,
   output logic rsp_last_result
);

   logic push, pop, q_empty, q_full;
   fsnb_pkg::entry_type push_entry, pop_entry;

   // Stall characters while no queue slot is free
   assign req_stall = q_full;

   fsnb_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_name_char(req_name_char),
      .req_last_char(req_last_char),
      .push(push),
      .push_entry(push_entry)
   );

   fsnb_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .pop(pop),
      .pop_entry(pop_entry),
      .empty(q_empty),
      .full(q_full)
   );

   fsnb_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_entry(pop_entry),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_name_class(rsp_name_class),
      .rsp_byte_index(rsp_byte_index),
      .rsp_short_byte(rsp_short_byte),
      .rsp_checksum(rsp_checksum),
      .rsp_last_result(rsp_last_result)
   );

endmodule

@@ sim/tb_fat_short_name_builder.sv @@
// Testbench for fat_short_name_builder: drives character transactions, predicts
// the short name bytes and LFN checksums, and checks every result transaction.
// Depends on rtl/fsnb_pkg.sv and the fat_short_name_builder RTL.
`timescale 1ns / 1ps

typedef struct {
   logic [1:0] name_class;
   logic [3:0] byte_index;
   logic [7:0] short_byte;
   logic [7:0] checksum;
   logic last_result;
} short_result_type;

// Predicts the result transactions of each name and checks the block's output
class short_name_predictor;
   logic [7:0] name_bytes [fsnb_pkg::STORE_DEPTH];
   logic [3:0] seen_count;
   logic [3:0] dot_pos;
   bit has_dot;
   bit too_long;
   bit bad_char;
   short_result_type expected_bytes [$];
   int mismatch_count;

   function new();
      mismatch_count = 0;
      clear_name();
   endfunction

   function void clear_name();
      seen_count = '0;
      dot_pos = '0;
      has_dot = 0;
      too_long = 0;
      bad_char = 0;
   endfunction

   // Uppercased stored byte, or a space past the end of the name
   function logic [7:0] name_byte_at(int pos);
      logic [7:0] c;
      if (pos >= int'(seen_count) || pos >= fsnb_pkg::STORE_DEPTH)
         return fsnb_pkg::BYTE_SPACE;
      c = name_bytes[pos];
      if (c >= fsnb_pkg::BYTE_LOWER_A && c <= fsnb_pkg::BYTE_LOWER_Z)
         c = c - (fsnb_pkg::BYTE_LOWER_A - "A");
      return c;
   endfunction

   // Note one accepted character; on the last one queue the expected results
   function void note_char(logic [15:0] c, logic fin);
      short_result_type r;
      logic [7:0] b;
      logic [7:0] sum;
      int k;
      if ((c < fsnb_pkg::CH_CTRL_END && c != fsnb_pkg::CH_E5_ESC) ||
          (c >= fsnb_pkg::CH_SURR_LO && c <= fsnb_pkg::CH_SURR_HI))
         bad_char = 1;
      if (c > fsnb_pkg::CH_ASCII_TOP) too_long = 1;
      if (c == fsnb_pkg::CH_DOT) begin
         has_dot = 1;
         dot_pos = seen_count;
      end
      if (seen_count < fsnb_pkg::STORE_DEPTH) name_bytes[seen_count] = c[7:0];
      if (seen_count != fsnb_pkg::COUNT_MAX) seen_count = seen_count + 1'b1;
      if (!fin) return;

      if (has_dot) begin
         if (dot_pos > fsnb_pkg::DOT_MAX_IDX || seen_count > fsnb_pkg::DOTTED_MAX_LEN)
            too_long = 1;
      end else if (seen_count > fsnb_pkg::BASE_MAX_LEN) begin
         too_long = 1;
      end

      if (bad_char || too_long) begin
         r.name_class = bad_char ? fsnb_pkg::CLASS_INVALID : fsnb_pkg::CLASS_LONG;
         r.byte_index = '0;
         r.short_byte = fsnb_pkg::BYTE_SPACE;
         r.checksum = '0;
         r.last_result = 1'b1;
         expected_bytes.push_back(r);
      end else begin
         sum = '0;
         for (k = 0; k <= int'(fsnb_pkg::SHORT_LAST_BYTE); k++) begin
            if (!has_dot) b = name_byte_at(k);
            else if (k < int'(fsnb_pkg::EXT_POS))
               b = (k < int'(dot_pos)) ? name_byte_at(k) : fsnb_pkg::BYTE_SPACE;
            else b = name_byte_at(int'(dot_pos) + 1 + k - int'(fsnb_pkg::EXT_POS));
            sum = {sum[0], sum[7:1]} + b;
            r.name_class = fsnb_pkg::CLASS_SHORT;
            r.byte_index = 4'(k);
            r.short_byte = b;
            r.checksum = sum;
            r.last_result = (k == int'(fsnb_pkg::SHORT_LAST_BYTE));
            expected_bytes.push_back(r);
         end
      end
      clear_name();
   endfunction

   function void report(string field, logic [7:0] want, logic [7:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endfunction

   // Compare one accepted result with the oldest expectation
   function void check_byte(logic [1:0] cls, logic [3:0] idx, logic [7:0] sb,
                            logic [7:0] cs, logic lr);
      short_result_type e;
      if (expected_bytes.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected result, expected none, actual class %h index %h byte %h",
                  $time, cls, idx, sb);
         return;
      end
      e = expected_bytes.pop_front();
      if (cls !== e.name_class) report("name_class", 8'(e.name_class), 8'(cls));
      if (idx !== e.byte_index) report("byte_index", 8'(e.byte_index), 8'(idx));
      if (sb !== e.short_byte) report("short_byte", e.short_byte, sb);
      if (cs !== e.checksum) report("checksum", e.checksum, cs);
      if (lr !== e.last_result) report("last_result", 8'(e.last_result), 8'(lr));
   endfunction
endclass

module tb_fat_short_name_builder;

   localparam int RANDOM_ITEMS = 200;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 1500;
   localparam int DRAIN_CYCLES = 30;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_name_char = '0;
   logic req_last_char = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_name_class;
   logic [3:0] rsp_byte_index;
   logic [7:0] rsp_short_byte;
   logic [7:0] rsp_checksum;
   logic rsp_last_result;

   short_name_predictor model;
   logic [15:0] name_buf [$];
   int sent_count = 0;
   bit send_idle = 1;
   bit recv_idle = 1;
   bit long_hold = 0;

   fat_short_name_builder u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_name_char(req_name_char),
      .req_last_char(req_last_char),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_name_class(rsp_name_class),
      .rsp_byte_index(rsp_byte_index),
      .rsp_short_byte(rsp_short_byte),
      .rsp_checksum(rsp_checksum),
      .rsp_last_result(rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int draw_wait(bit on);
      return on ? int'($urandom_range(0, 11)) : 0;
   endfunction

   // Mostly letters and digits; otherwise printable ASCII or the 0x05 escape code
   function automatic logic [15:0] plain_char();
      case ($urandom_range(0, 7))
         0, 1, 2: return 16'("a") + 16'($urandom_range(0, 25));
         3, 4: return 16'("A") + 16'($urandom_range(0, 25));
         5: return 16'("0") + 16'($urandom_range(0, 9));
         6: return 16'($urandom_range(fsnb_pkg::CH_CTRL_END, fsnb_pkg::CH_ASCII_TOP));
         default: return ($urandom_range(0, 3) == 0) ? fsnb_pkg::CH_E5_ESC : 16'("_");
      endcase
   endfunction

   // Offer one character transaction and hold it until accepted
   task automatic send_char(input logic [15:0] c, input logic fin);
      int gap;
      gap = draw_wait(send_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_name_char <= c;
      req_last_char <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model.note_char(c, fin);
      sent_count++;
   endtask

   task automatic send_buf();
      int k;
      for (k = 0; k < name_buf.size(); k++) send_char(name_buf[k], k == name_buf.size() - 1);
   endtask

   task automatic send_text(input string s);
      int k;
      name_buf.delete();
      for (k = 0; k < s.len(); k++) name_buf.push_back(16'(s[k]));
      send_buf();
   endtask

   task automatic send_single(input logic [15:0] c);
      name_buf.delete();
      name_buf.push_back(c);
      send_buf();
   endtask

   // Mostly well-formed 8.3 names; some too long, some pure noise
   task automatic send_random_name(input bit noisy);
      int base_len;
      int ext_len;
      int k;
      name_buf.delete();
      if (noisy) begin
         base_len = $urandom_range(1, 16);
         for (k = 0; k < base_len; k++)
            name_buf.push_back($urandom_range(0, 1) ? 16'($urandom) : plain_char());
      end else begin
         base_len = $urandom_range(0, 8);
         ext_len = $urandom_range(0, 3);
         if ($urandom_range(0, 7) == 0) begin
            base_len += 3;
            ext_len += 2;
         end
         if ($urandom_range(0, 3) == 0) begin
            if (base_len == 0) base_len = 1;
            for (k = 0; k < base_len; k++) name_buf.push_back(plain_char());
         end else begin
            for (k = 0; k < base_len; k++) name_buf.push_back(plain_char());
            name_buf.push_back(fsnb_pkg::CH_DOT);
            for (k = 0; k < ext_len; k++) name_buf.push_back(plain_char());
         end
      end
      send_buf();
   endtask

   // Result side: check each accepted transaction, then draw the next stall
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            model.check_byte(rsp_name_class, rsp_byte_index, rsp_short_byte, rsp_checksum,
                             rsp_last_result);
            hold = draw_wait(recv_idle);
         end else if (hold > 0) begin
            hold--;
         end
         if (long_hold) begin
            hold = HOLD_CYCLES;
            long_hold = 0;
         end
         rsp_stall <= (hold > 0);
      end
   end

   // Abort when no transaction moves on either side for too long
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int target;
      model = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed names: case and digit bounds, dots, escape byte, bad characters
      send_text("a");
      send_text("az.09~");
      send_text(".x");
      send_text("a.b.c");
      name_buf.delete();
      name_buf.push_back(fsnb_pkg::CH_E5_ESC);
      name_buf.push_back(16'("m"));
      send_buf();
      name_buf.delete();
      name_buf.push_back(16'h00FF);
      name_buf.push_back(16'h0000);
      send_buf();
      send_single(fsnb_pkg::CH_CTRL_END - 16'd1);
      send_single(fsnb_pkg::CH_SURR_LO);
      send_single(fsnb_pkg::CH_SURR_HI);
      send_single(fsnb_pkg::CH_SURR_HI + 16'd1);
      send_single(fsnb_pkg::CH_ASCII_TOP + 16'd1);
      send_single(fsnb_pkg::CH_CTRL_END);

      // Hold the result side off while names keep coming, so the input stalls
      send_idle = 0;
      recv_idle = 0;
      long_hold = 1;
      repeat (6) send_random_name(0);
      send_idle = 1;
      recv_idle = 1;

      // Random names with shifting idle patterns on both sides
      target = sent_count + RANDOM_ITEMS;
      while (sent_count < target) begin
         if ($urandom_range(0, 7) == 0) send_idle = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 7) == 0) recv_idle = ($urandom_range(0, 3) != 0);
         send_random_name($urandom_range(0, 3) == 0);
      end
      req_valid <= 1'b0;

      // Drain, then allow the back end to finish any trailing work
      while (model.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (model.mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
